// ===== rtl/fixed_pool_free_list_defines.svh =====
// Assertion helpers for the pool free list
`ifndef FIXED_POOL_FREE_LIST_DEFINES_SVH
`define FIXED_POOL_FREE_LIST_DEFINES_SVH

`ifndef SYNTHESIS

`define FPFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FPFL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define FPFL_ASSERT(lbl, prop, msg)

`define FPFL_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== rtl/fpfl_pkg.sv =====
package fpfl_pkg;

  localparam int MAX_SLOTS   = 256;
  localparam int ALIGN_BYTES = 16;
  localparam int ELEM_LIMIT  = 4096;

  localparam int SLOT_W   = $clog2(MAX_SLOTS);
  localparam int LINK_W   = SLOT_W + 1;
  localparam int COUNT_W  = 9;
  localparam int ELEM_W   = 13;
  localparam int STRIDE_W = 13;
  localparam int OFFS_W   = 20;
  localparam int CFG_W    = 13;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_SLOTS);

  localparam logic [0:0] CFG_SLOT_COUNT    = 1'b0;
  localparam logic [0:0] CFG_ELEMENT_BYTES = 1'b1;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FREED     = 2'd2,
    ST_NULL_FREE = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE     = 1'b0,
    S_ALLOC_RD = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [COUNT_W-1:0] free_slot;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_index;
    logic [OFFS_W-1:0] slot_offset;
  } out_word_t;

endpackage

// ===== rtl/fixed_pool_free_list.sv =====
// Free word or rejected command: result strobed in the cycle after acceptance.
// Successful allocate: link memory read in S_ALLOC_RD, then the registered result.
// busy is high for the read cycle of an allocate; a free issues every cycle.
// Synchronous active-low reset; the receiver cannot stall the result port.
// Reset and any config write relink all slots at once through per-slot valid
// flags; no clearing pass is needed.
module fixed_pool_free_list (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  fpfl_pkg::in_word_t              in_word,
  output logic                            out_valid,
  output fpfl_pkg::out_word_t             out_word,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_addr,
  input  logic [fpfl_pkg::CFG_W-1:0]      cfg_wdata
);

`include "fixed_pool_free_list_defines.svh"

  localparam int SLOT_W = fpfl_pkg::SLOT_W;
  localparam int LINK_W = fpfl_pkg::LINK_W;
  localparam int PROD_W = SLOT_W + fpfl_pkg::STRIDE_W;

  fpfl_pkg::state_t                     state_r, state_nxt;
  logic [LINK_W-1:0]                    head_r, head_nxt;
  logic [fpfl_pkg::MAX_SLOTS-1:0]       valid_r, valid_nxt;
  logic [fpfl_pkg::COUNT_W-1:0]         slot_count_r;
  logic [fpfl_pkg::STRIDE_W-1:0]        stride_r;
  logic                                 out_valid_r, out_valid_nxt;
  fpfl_pkg::out_word_t                  out_word_r, out_word_nxt;

  logic [LINK_W-1:0] mem [fpfl_pkg::MAX_SLOTS];
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic              rd_en;
  logic [LINK_W-1:0] rd_data_r;
  logic              rd_vld_r;

  logic                          accept;
  logic [LINK_W-1:0]             dflt_link;
  logic [LINK_W-1:0]             link;
  logic [PROD_W-1:0]             prod;
  logic [fpfl_pkg::COUNT_W-1:0]  sc_clamp;
  logic [fpfl_pkg::ELEM_W-1:0]   eb_clamp;
  logic [fpfl_pkg::ELEM_W:0]     eb_round;

  assign accept = start && (state_r == fpfl_pkg::S_IDLE);
  assign busy   = (state_r != fpfl_pkg::S_IDLE);

  // link of a never-written entry: next slot in order, or null at the end
  assign dflt_link = ((head_r + LINK_W'(1)) < LINK_W'(slot_count_r)) ?
                     (head_r + LINK_W'(1)) : fpfl_pkg::NULL_LINK;
  assign link = rd_vld_r ? rd_data_r : dflt_link;
  assign prod = PROD_W'(head_r[SLOT_W-1:0]) * PROD_W'(stride_r);

  always_comb begin
    sc_clamp = cfg_wdata[fpfl_pkg::COUNT_W-1:0];
    if (sc_clamp == '0) begin
      sc_clamp = fpfl_pkg::COUNT_W'(1);
    end else if (sc_clamp > fpfl_pkg::COUNT_W'(fpfl_pkg::MAX_SLOTS)) begin
      sc_clamp = fpfl_pkg::COUNT_W'(fpfl_pkg::MAX_SLOTS);
    end
    eb_clamp = cfg_wdata[fpfl_pkg::ELEM_W-1:0];
    if (eb_clamp == '0) begin
      eb_clamp = fpfl_pkg::ELEM_W'(1);
    end else if (eb_clamp > fpfl_pkg::ELEM_W'(fpfl_pkg::ELEM_LIMIT)) begin
      eb_clamp = fpfl_pkg::ELEM_W'(fpfl_pkg::ELEM_LIMIT);
    end
    // round up to the alignment, a power of two
    eb_round = ((fpfl_pkg::ELEM_W+1)'(eb_clamp) +
                (fpfl_pkg::ELEM_W+1)'(fpfl_pkg::ALIGN_BYTES - 1)) &
               ~((fpfl_pkg::ELEM_W+1)'(fpfl_pkg::ALIGN_BYTES - 1));
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_waddr     = in_word.free_slot[SLOT_W-1:0];
    mem_wdata     = head_r;
    rd_en         = 1'b0;
    case (state_r)
      fpfl_pkg::S_IDLE: begin
        if (accept) begin
          if (in_word.cmd == fpfl_pkg::CMD_ALLOC) begin
            if (head_r < LINK_W'(slot_count_r)) begin
              rd_en     = 1'b1;
              state_nxt = fpfl_pkg::S_ALLOC_RD;
            end else begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{fpfl_pkg::ST_EMPTY, '0, '0};
            end
          end else begin
            out_valid_nxt = 1'b1;
            if (in_word.free_slot < slot_count_r) begin
              mem_we                                  = 1'b1;
              valid_nxt[in_word.free_slot[SLOT_W-1:0]] = 1'b1;
              head_nxt                                = LINK_W'(in_word.free_slot);
              out_word_nxt = '{fpfl_pkg::ST_FREED, '0, '0};
            end else begin
              out_word_nxt = '{fpfl_pkg::ST_NULL_FREE, '0, '0};
            end
          end
        end
      end
      fpfl_pkg::S_ALLOC_RD: begin
        head_nxt      = link;
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{fpfl_pkg::ST_ALLOCATED, head_r[SLOT_W-1:0],
                          prod[fpfl_pkg::OFFS_W-1:0]};
        state_nxt     = fpfl_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fpfl_pkg::S_IDLE;
      end
    endcase
    if (cfg_we) begin
      valid_nxt = '0;
      head_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fpfl_pkg::S_IDLE;
      head_r       <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      slot_count_r <= fpfl_pkg::COUNT_W'(fpfl_pkg::MAX_SLOTS);
      stride_r     <= fpfl_pkg::STRIDE_W'(16);
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          fpfl_pkg::CFG_SLOT_COUNT: begin
            slot_count_r <= sc_clamp;
          end
          fpfl_pkg::CFG_ELEMENT_BYTES: begin
            stride_r <= eb_round[fpfl_pkg::STRIDE_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[head_r[SLOT_W-1:0]];
      rd_vld_r  <= valid_r[head_r[SLOT_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `FPFL_ASSERT_NEXT(a_alloc_reads,
    accept && (in_word.cmd == fpfl_pkg::CMD_ALLOC) &&
    (head_r < LINK_W'(slot_count_r)) && !cfg_we,
    state_r == fpfl_pkg::S_ALLOC_RD, "allocate did not enter read cycle")
  `FPFL_ASSERT_NEXT(a_read_answers, state_r == fpfl_pkg::S_ALLOC_RD,
    out_valid_r && (out_word_r.status == fpfl_pkg::ST_ALLOCATED),
    "read cycle gave no allocation")
  `FPFL_ASSERT(a_index_in_pool,
    (out_valid_r && (out_word_r.status == fpfl_pkg::ST_ALLOCATED)) |->
    (fpfl_pkg::COUNT_W'(out_word_r.slot_index) < slot_count_r),
    "allocated slot outside pool")

endmodule

// ===== tb/fpfl_checker.sv =====
module fpfl_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  fpfl_pkg::in_word_t         in_word,
  input  logic                       out_valid,
  input  fpfl_pkg::out_word_t        out_word,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_addr,
  input  logic [fpfl_pkg::CFG_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending
);
  import fpfl_pkg::*;

  logic [LINK_W-1:0] pool_link [MAX_SLOTS];
  logic [LINK_W-1:0] free_head;
  int unsigned       pool_slots;
  int unsigned       elem_bytes;
  out_word_t         expected_words [$];
  int                fails = 0;

  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic relink_pool();
    for (int i = 0; i < MAX_SLOTS; i++) begin
      pool_link[i] = (i + 1 < pool_slots) ? LINK_W'(i + 1) : NULL_LINK;
    end
    free_head = '0;
  endtask

  task automatic serve_request(input in_word_t w, output out_word_t r);
    int unsigned stride;
    r = '0;
    stride = (elem_bytes + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
    if (w.cmd == CMD_ALLOC) begin
      if (free_head < pool_slots) begin
        r.status      = ST_ALLOCATED;
        r.slot_index  = free_head[SLOT_W-1:0];
        r.slot_offset = OFFS_W'(free_head * stride);
        free_head     = pool_link[free_head[SLOT_W-1:0]];
      end else begin
        r.status = ST_EMPTY;
      end
    end else if (w.free_slot < pool_slots) begin
      pool_link[w.free_slot[SLOT_W-1:0]] = free_head;
      free_head = w.free_slot;
      r.status  = ST_FREED;
    end else begin
      r.status = ST_NULL_FREE;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      pool_slots = MAX_SLOTS;
      elem_bytes = 16;
      relink_pool();
      expected_words.delete();
    end else begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (out_word.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_word.status);
            fails++;
          end
          if (out_word.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, out_word.slot_index);
            fails++;
          end
          if (out_word.slot_offset !== want.slot_offset) begin
            $error("slot_offset: expected %0d, got %0d",
                   want.slot_offset, out_word.slot_offset);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        serve_request(in_word, want);
        expected_words.push_back(want);
      end
      if (cfg_we) begin
        if (cfg_addr == CFG_SLOT_COUNT) begin
          pool_slots = clamp_reg(cfg_wdata[COUNT_W-1:0], MAX_SLOTS);
        end else begin
          elem_bytes = clamp_reg(cfg_wdata[ELEM_W-1:0], ELEM_LIMIT);
        end
        relink_pool();
      end
    end
    fail_count <= fails;
    pending    <= expected_words.size();
  end

endmodule

// ===== tb/tb_fixed_pool_free_list.sv =====
module tb_fixed_pool_free_list;
  import fpfl_pkg::*;

  localparam int N_PHASES   = 12;
  localparam int DEEP_PHASE = 3;
  localparam int CALM_PHASE = 4;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_word_t          in_word;
  logic              out_valid;
  out_word_t         out_word;
  logic              cfg_we;
  logic [0:0]        cfg_addr;
  logic [CFG_W-1:0]  cfg_wdata;
  int                fail_count;
  int                pending;

  logic [SLOT_W-1:0] held_slots [$];
  int                idle_pct;
  int                alloc_pct;
  int unsigned       count_val [6] = '{0, 2, 511, 256, 5, 300};
  int unsigned       bytes_val [6] = '{0, 4096, 8191, 4096, 17, 1};

  fixed_pool_free_list dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  fpfl_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // slots handed out, so that most frees return something live
  always @(negedge clk) begin
    if (rst_n && out_valid && out_word.status == ST_ALLOCATED) begin
      held_slots.push_back(out_word.slot_index);
    end
  end

  task automatic send(input cmd_t c, input logic [COUNT_W-1:0] s);
    start   <= 1'b1;
    in_word <= '{cmd: c, free_slot: s};
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_maybe();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned slots, input int unsigned bytes);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SLOT_COUNT;
    cfg_wdata <= CFG_W'(slots);
    @(posedge clk);
    cfg_addr  <= CFG_ELEMENT_BYTES;
    cfg_wdata <= CFG_W'(bytes);
    @(posedge clk);
    cfg_we <= 1'b0;
    held_slots.delete();
    @(posedge clk);
  endtask

  function automatic logic [COUNT_W-1:0] pick_free();
    int k;
    if (held_slots.size() > 0 && $urandom_range(99) < 85) begin
      k = $urandom_range(held_slots.size() - 1);
      pick_free = COUNT_W'(held_slots[k]);
      held_slots.delete(k);
    end else begin
      case ($urandom_range(3))
        0:       pick_free = NULL_LINK;
        1:       pick_free = COUNT_W'($urandom_range(511));
        2:       pick_free = COUNT_W'($urandom_range(255));
        default: pick_free = COUNT_W'($urandom_range(8));
      endcase
    end
  endfunction

  initial begin
    int unsigned slots;
    int unsigned bytes;
    int          n_words;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '{cmd: CMD_ALLOC, free_slot: '0};
    cfg_we    = 1'b0;
    cfg_addr  = CFG_SLOT_COUNT;
    cfg_wdata = '0;
    idle_pct  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset pool: in-order pops, null and out-of-pool frees, double free
    send(CMD_ALLOC, '0);
    send(CMD_ALLOC, '1);
    send(CMD_ALLOC, '0);
    send(CMD_FREE, 9'd1);
    send(CMD_FREE, NULL_LINK);
    send(CMD_FREE, 9'h1FF);
    send(CMD_FREE, 9'd300);
    send(CMD_ALLOC, '0);
    send(CMD_FREE, 9'd0);
    send(CMD_FREE, 9'd0);
    send(CMD_ALLOC, '0);
    send(CMD_ALLOC, '0);
    send(CMD_FREE, 9'd255);
    send(CMD_ALLOC, '0);
    settle();

    // zero count and zero size are taken as one
    set_config(0, 0);
    send(CMD_ALLOC, '0);
    send(CMD_ALLOC, '0);
    send(CMD_FREE, 9'd1);
    send(CMD_FREE, 9'd0);
    send(CMD_ALLOC, '0);
    settle();

    // oversized values saturate
    set_config(511, 4097);
    send(CMD_ALLOC, '0);
    send(CMD_ALLOC, '0);
    send(CMD_FREE, 9'd0);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 6) begin
        slots = count_val[p];
        bytes = bytes_val[p];
      end else begin
        slots = $urandom_range(1, 16);
        bytes = $urandom_range(0, 8191);
      end
      set_config(slots, bytes);
      idle_pct  = (p == CALM_PHASE) ? 0 : 40;
      alloc_pct = (p == DEEP_PHASE) ? 90 : $urandom_range(35, 70);
      n_words   = (p == DEEP_PHASE) ? 330 : 75;
      for (int i = 0; i < n_words; i++) begin
        if ($urandom_range(99) < alloc_pct) begin
          send(CMD_ALLOC, COUNT_W'($urandom_range(511)));
        end else begin
          send(CMD_FREE, pick_free());
        end
        pause_maybe();
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
